FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the timeout table scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/tts_pkg.sv
// Shared types and constants of the timeout table scheduler.
package tts_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [15:0] IDLE_WAIT_RST = 16'd500;

    localparam logic [2:0] MODE_SET     = 3'd0;
    localparam logic [2:0] MODE_CLEAR   = 3'd1;
    localparam logic [2:0] MODE_QUERY   = 3'd2;
    localparam logic [2:0] MODE_CHECK   = 3'd3;
    localparam logic [2:0] MODE_NEAREST = 3'd4;
    localparam logic [2:0] MODE_TICK    = 3'd5;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] key;
        logic [31:0] cookie;
        logic [31:0] order;
    } t_slot;

endpackage

FILE: hdl/tts_slot_store.sv
// Slot memory of the timeout table with one write port and one registered read port.
module tts_slot_store #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF,
    localparam int IDXW = $clog2(SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [IDXW-1:0]      i_waddr,
    input  tts_pkg::t_slot       i_wdata,
    input  logic                 i_re,
    input  logic [IDXW-1:0]      i_raddr,
    output logic                 o_rvalid,
    output logic [IDXW-1:0]      o_ridx,
    output tts_pkg::t_slot       o_rdata
);

    tts_pkg::t_slot r_mem [SLOTS];
    tts_pkg::t_slot r_rdata;
    logic [IDXW-1:0] r_ridx;
    logic            r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_ridx  <= i_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= i_re;
        end
    end

    assign o_rvalid = r_rvalid;
    assign o_ridx   = r_ridx;
    assign o_rdata  = r_rdata;

endmodule

FILE: hdl/timeout_table_scheduler.sv
// Top level of the timeout table scheduler: command decode, slot scan and result words.
//
// A word is taken when start is high and busy is low, and its result appears in the next
// cycle or after the scan, with o_strobe high for exactly one cycle; the receiver cannot
// hold it off. Set and tick need no scan: the lowest free slot comes from the valid bits
// and the entry is written at acceptance. Clear, query, check and nearest read the slot
// memory through its single read port, one slot per cycle, so they keep busy high through
// the scan and drop it in the cycle in which the result is strobed.
// A new word may be started in the cycle in which the previous result is strobed.
`include "assert_macros.svh"

module timeout_table_scheduler #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic [23:0]        i_delay_ms,
    input  logic [15:0]        i_key,
    input  logic [31:0]        i_arg,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic               o_scheduled,
    output logic [15:0]        o_fired_key,
    output logic [31:0]        o_fired_arg,
    output logic signed [31:0] o_nearest_ms
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                r_state, n_state;
    logic [2:0]          r_op, n_op;
    logic [15:0]         r_key, n_key;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [31:0]         r_now, n_now;
    logic [31:0]         r_next_order, n_next_order;
    logic [15:0]         r_idle_wait;

    logic                r_found, n_found;
    logic                r_hit, n_hit;
    logic [31:0]         r_best_age, n_best_age;
    logic signed [31:0]  r_best_rem, n_best_rem;
    logic [IDXW-1:0]     r_pick, n_pick;
    logic [15:0]         r_fkey, n_fkey;
    logic [31:0]         r_farg, n_farg;

    logic                r_strobe, n_strobe;
    logic [1:0]          r_status, n_status;
    logic                r_sched, n_sched;
    logic [15:0]         r_out_key, n_out_key;
    logic [31:0]         r_out_arg, n_out_arg;
    logic signed [31:0]  r_out_near, n_out_near;

    logic                full;
    logic [IDXW-1:0]     free_idx;
    logic                wr_en;
    tts_pkg::t_slot      wr_data;
    logic                rd_en;
    logic                rd_vld;
    logic [IDXW-1:0]     rd_idx;
    tts_pkg::t_slot      rd_data;

    logic                ev_v;
    logic                ev_match;
    logic                ev_due;
    logic [31:0]         ev_lag;
    logic [31:0]         ev_age;
    logic signed [31:0]  ev_rem;

    tts_slot_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (wr_en),
        .i_waddr  (free_idx),
        .i_wdata  (wr_data),
        .i_re     (rd_en),
        .i_raddr  (r_cnt[IDXW-1:0]),
        .o_rvalid (rd_vld),
        .o_ridx   (rd_idx),
        .o_rdata  (rd_data)
    );

    assign full = &r_valid;

    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDXW'(i);
            end
        end
    end

    assign wr_data.deadline = r_now + {8'd0, i_delay_ms};
    assign wr_data.key      = i_key;
    assign wr_data.cookie   = i_arg;
    assign wr_data.order    = r_next_order;

    assign ev_v     = r_valid[rd_idx];
    assign ev_match = ev_v && (rd_data.key == r_key);
    assign ev_lag   = r_now - rd_data.deadline;
    assign ev_due   = ev_v && !ev_lag[31];
    assign ev_age   = r_next_order - rd_data.order;
    assign ev_rem   = signed'(rd_data.deadline - r_now);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_cnt        = r_cnt;
        n_valid      = r_valid;
        n_now        = r_now;
        n_next_order = r_next_order;
        n_found      = r_found;
        n_hit        = r_hit;
        n_best_age   = r_best_age;
        n_best_rem   = r_best_rem;
        n_pick       = r_pick;
        n_fkey       = r_fkey;
        n_farg       = r_farg;
        n_strobe     = 1'b0;
        n_status     = r_status;
        n_sched      = r_sched;
        n_out_key    = r_out_key;
        n_out_arg    = r_out_arg;
        n_out_near   = r_out_near;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_status   = tts_pkg::STAT_DONE;
                    n_sched    = 1'b0;
                    n_out_key  = '0;
                    n_out_arg  = '0;
                    n_out_near = '0;
                    case (i_mode)
                        tts_pkg::MODE_SET: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_status = tts_pkg::STAT_FULL;
                            end else begin
                                wr_en             = 1'b1;
                                n_valid[free_idx] = 1'b1;
                                n_next_order      = r_next_order + 32'd1;
                            end
                        end
                        tts_pkg::MODE_TICK: begin
                            n_strobe = 1'b1;
                            n_now    = r_now + 32'd1;
                        end
                        tts_pkg::MODE_CLEAR, tts_pkg::MODE_QUERY,
                        tts_pkg::MODE_CHECK, tts_pkg::MODE_NEAREST: begin
                            n_state = ST_SCAN;
                            n_op    = i_mode;
                            n_key   = i_key;
                            n_cnt   = '0;
                            n_found = 1'b0;
                            n_hit   = 1'b0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_cnt < CNTW'(SLOTS)) begin
                    rd_en = 1'b1;
                    n_cnt = r_cnt + CNTW'(1);
                end
                if (rd_vld) begin
                    case (r_op)
                        tts_pkg::MODE_CLEAR: begin
                            if (ev_match) begin
                                n_valid[rd_idx] = 1'b0;
                            end
                        end
                        tts_pkg::MODE_QUERY: begin
                            if (ev_match) begin
                                n_hit = 1'b1;
                            end
                        end
                        tts_pkg::MODE_CHECK: begin
                            if (ev_due && (!r_found || (ev_age > r_best_age))) begin
                                n_found    = 1'b1;
                                n_best_age = ev_age;
                                n_pick     = rd_idx;
                                n_fkey     = rd_data.key;
                                n_farg     = rd_data.cookie;
                            end
                        end
                        tts_pkg::MODE_NEAREST: begin
                            if (ev_v && (!r_found || (ev_rem < r_best_rem))) begin
                                n_found    = 1'b1;
                                n_best_rem = ev_rem;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (r_cnt == CNTW'(SLOTS)) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    case (r_op)
                        tts_pkg::MODE_QUERY: begin
                            n_sched = r_hit;
                        end
                        tts_pkg::MODE_CHECK: begin
                            if (r_found) begin
                                n_out_key       = r_fkey;
                                n_out_arg       = r_farg;
                                n_valid[r_pick] = 1'b0;
                            end else begin
                                n_status = tts_pkg::STAT_EMPTY;
                            end
                        end
                        tts_pkg::MODE_NEAREST: begin
                            if (r_found) begin
                                n_out_near = r_best_rem;
                            end else begin
                                n_status   = tts_pkg::STAT_EMPTY;
                                n_out_near = signed'({16'd0, r_idle_wait});
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_now        <= '0;
            r_next_order <= '0;
            r_idle_wait  <= tts_pkg::IDLE_WAIT_RST;
            r_strobe     <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_now        <= n_now;
            r_next_order <= n_next_order;
            r_strobe     <= n_strobe;
            r_cnt        <= n_cnt;
            if (i_cfg_we) begin
                r_idle_wait <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_found    <= n_found;
        r_hit      <= n_hit;
        r_best_age <= n_best_age;
        r_best_rem <= n_best_rem;
        r_pick     <= n_pick;
        r_fkey     <= n_fkey;
        r_farg     <= n_farg;
        r_status   <= n_status;
        r_sched    <= n_sched;
        r_out_key  <= n_out_key;
        r_out_arg  <= n_out_arg;
        r_out_near <= n_out_near;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_scheduled  = r_sched;
    assign o_fired_key  = r_out_key;
    assign o_fired_arg  = r_out_arg;
    assign o_nearest_ms = r_out_near;

    `ASSERT_IMPLY(a_full_only_when_full, i_clk, i_rst_n, o_strobe && (o_status == tts_pkg::STAT_FULL), $past(full))
    `ASSERT_NEXT(a_scan_ends_in_word, i_clk, i_rst_n, (r_state == ST_SCAN) && (r_cnt == CNTW'(SLOTS)) && !rd_vld, o_strobe && !busy)
    `ASSERT_IMPLY(a_strobe_has_source, i_clk, i_rst_n, o_strobe, $past(r_state == ST_SCAN) || $past(start && !busy))

endmodule
